FILE: src/kruskal_union_find_mst_defines.svh
// Assertion macros shared by the union-find engine files
`ifndef KRUSKAL_UNION_FIND_MST_DEFINES_SVH
`define KRUSKAL_UNION_FIND_MST_DEFINES_SVH

// Assert that a condition implies a consequence on the same edge
`define KUF_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Assert that a condition implies a consequence on the next edge
`define KUF_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/kuf_pkg.sv
`default_nettype none
package kuf_pkg;

  localparam int unsigned NODE_W   = 10;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned WGT_W    = 32;
  localparam int unsigned TOT_W    = 42;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned QDEPTH   = 2;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Command handed from the front end to the execution engine
  typedef struct packed {
    logic              clear;
    logic              bad;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [WGT_W-1:0]  weight;
  } cmd_t;

  typedef struct packed {
    logic              accepted;
    logic              bad;
    logic [TOT_W-1:0]  total;
    logic [CNT_W-1:0]  count;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RDA,
    ST_WALKA,
    ST_RDB,
    ST_WALKB,
    ST_RDLINK,
    ST_FIX,
    ST_RESULT
  } eng_state_t;

endpackage
`default_nettype wire

FILE: src/kuf_front.sv
`default_nettype none
`include "kruskal_union_find_mst_defines.svh"
module kuf_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        opcode,
  input  wire logic [kuf_pkg::NODE_W-1:0]  edge_from,
  input  wire logic [kuf_pkg::NODE_W-1:0]  edge_to,
  input  wire logic [kuf_pkg::WGT_W-1:0]   edge_weight,
  input  wire logic [kuf_pkg::CFG_W-1:0]   limit,
  output logic                             cmd_valid,
  output kuf_pkg::cmd_t                    cmd,
  input  wire logic                        cmd_take
);

  kuf_pkg::cmd_t   q [kuf_pkg::QDEPTH];
  logic            wptr, rptr;
  logic [1:0]      fill;
  kuf_pkg::cmd_t   incoming;
  logic            do_push, do_pop;

  // Classify the transaction: range check against the active node limit
  always_comb begin
    incoming.clear  = (opcode == kuf_pkg::OP_CLEAR);
    incoming.bad    = (opcode == kuf_pkg::OP_EDGE) &&
                      (({1'b0, edge_from} >= limit) || ({1'b0, edge_to} >= limit));
    incoming.node_a = edge_from;
    incoming.node_b = edge_to;
    incoming.weight = edge_weight;
  end

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // Hold queue entries
  always_ff @(posedge clk) begin
    if (do_push) q[wptr] <= incoming;
  end

  // Advance pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `KUF_ASSERT_IMP(a_no_overflow, clk, rst, full, !do_push, "queue overflow")
  `KUF_ASSERT_IMP(a_no_underflow, clk, rst, fill == 2'd0, !do_pop, "queue underflow")
  `KUF_ASSERT_IMP(a_fill_range, clk, rst, 1'b1, fill != 2'd3, "fill out of range")

endmodule
`default_nettype wire

FILE: src/kuf_engine.sv
`default_nettype none
`include "kruskal_union_find_mst_defines.svh"
module kuf_engine #(
  parameter int unsigned MAX_NODES = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [kuf_pkg::CFG_W-1:0]  limit,
  input  wire logic                       cmd_valid,
  input  wire kuf_pkg::cmd_t              cmd,
  output logic                            cmd_take,
  output logic                            res_valid,
  output kuf_pkg::res_t                   res,
  input  wire logic                       res_take
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned SW = $clog2(MAX_NODES + 1);
  localparam logic [kuf_pkg::NODE_W:0] MAXN =
    (MAX_NODES > 1024) ? 11'd1024 : (kuf_pkg::NODE_W + 1)'(MAX_NODES);

  // Parent table: one write port, one registered read port
  logic [kuf_pkg::NODE_W-1:0] mem [MAX_NODES];
  logic [kuf_pkg::NODE_W-1:0] rdata;
  logic [AW-1:0]              raddr, waddr;
  logic                       we;
  logic [kuf_pkg::NODE_W-1:0] wdata;
  logic                       boot;   // clearing pass after reset, no result

  kuf_pkg::eng_state_t state, state_next;
  kuf_pkg::cmd_t       cur;
  logic [kuf_pkg::NODE_W-1:0] x, root_a, link;
  logic [kuf_pkg::NODE_W-1:0] x_next;
  logic [SW-1:0]              steps, steps_next;
  logic [kuf_pkg::NODE_W:0]   clr_idx;
  logic [kuf_pkg::NODE_W-1:0] pval;
  logic                       is_root, step_cap;
  logic [kuf_pkg::TOT_W-1:0]  total;
  logic [kuf_pkg::CNT_W-1:0]  count;
  logic [kuf_pkg::TOT_W:0]    sum;
  logic                       acc;
  logic [kuf_pkg::NODE_W:0]   clr_lim;
  logic [kuf_pkg::NODE_W:0]   clr_end;

  // Read port and write port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  // Parent of the node read last cycle
  assign pval     = rdata;
  assign is_root  = (pval == x) || ({1'b0, pval} >= MAXN);
  assign step_cap = (steps >= SW'(MAX_NODES));
  assign clr_lim  = (limit < MAXN) ? limit : MAXN;
  assign clr_end  = boot ? MAXN : clr_lim;
  assign sum      = {1'b0, total} + {{(kuf_pkg::TOT_W-kuf_pkg::WGT_W+1){1'b0}}, cur.weight};

  // Sequencer for clear, root walks and path relinking
  always_comb begin
    state_next = state;
    x_next     = x;
    steps_next = steps;
    raddr      = AW'(x);
    we         = 1'b0;
    waddr      = AW'(clr_idx);
    wdata      = clr_idx[kuf_pkg::NODE_W-1:0];
    cmd_take   = 1'b0;
    unique case (state)
      kuf_pkg::ST_IDLE: begin
        raddr = AW'(cmd.node_a);
        if (cmd_valid) begin
          cmd_take = 1'b1;
          if (cmd.clear)     state_next = kuf_pkg::ST_CLEAR;
          else if (cmd.bad)  state_next = kuf_pkg::ST_RESULT;
          else               state_next = kuf_pkg::ST_WALKA;
          x_next     = cmd.node_a;
          steps_next = '0;
        end
      end
      kuf_pkg::ST_CLEAR: begin
        if (clr_idx < clr_end) we = 1'b1;
        else if (boot) state_next = kuf_pkg::ST_IDLE;
        else state_next = kuf_pkg::ST_RESULT;
      end
      kuf_pkg::ST_RDA: state_next = kuf_pkg::ST_FIX;
      kuf_pkg::ST_WALKA: begin
        if (is_root || step_cap) begin
          x_next = cur.node_b;
          steps_next = '0;
          raddr = AW'(cur.node_b);
          state_next = kuf_pkg::ST_WALKB;
        end else begin
          x_next = pval;
          steps_next = steps + 1'b1;
          raddr = AW'(pval);
        end
      end
      kuf_pkg::ST_RDB: state_next = kuf_pkg::ST_WALKB;
      kuf_pkg::ST_WALKB: begin
        if (is_root || step_cap) begin
          if (x == root_a) begin
            state_next = kuf_pkg::ST_RESULT;
          end else begin
            raddr = AW'(cur.node_b);
            state_next = kuf_pkg::ST_RDLINK;
          end
        end else begin
          x_next = pval;
          steps_next = steps + 1'b1;
          raddr = AW'(pval);
        end
      end
      kuf_pkg::ST_RDLINK: begin
        // pval here is parent of node_b; x reused after capture
        x_next = cur.node_a;
        steps_next = '0;
        raddr = AW'(cur.node_a);
        state_next = kuf_pkg::ST_FIX;
      end
      kuf_pkg::ST_FIX: begin
        we = 1'b1;
        waddr = AW'(x);
        if (is_root || step_cap) begin
          wdata = link;
          state_next = kuf_pkg::ST_RESULT;
        end else begin
          wdata = cur.node_b;
          x_next = pval;
          steps_next = steps + 1'b1;
          raddr = AW'(pval);
          state_next = kuf_pkg::ST_RDA;
        end
      end
      kuf_pkg::ST_RESULT: begin
        if (!res_valid) state_next = kuf_pkg::ST_IDLE;
      end
      default: state_next = kuf_pkg::ST_IDLE;
    endcase
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kuf_pkg::ST_CLEAR;
      boot      <= 1'b1;
      total     <= '0;
      count     <= '0;
      res_valid <= 1'b0;
      clr_idx   <= '0;
    end else begin
      state <= state_next;
      if (res_take) res_valid <= 1'b0;
      if (state == kuf_pkg::ST_IDLE && cmd_valid) begin
        clr_idx <= '0;
        acc     <= 1'b0;
      end
      if (state == kuf_pkg::ST_CLEAR && we) clr_idx <= clr_idx + 1'b1;
      if (state == kuf_pkg::ST_CLEAR && !we) begin
        boot  <= 1'b0;
        total <= '0;
        count <= '0;
      end
      if (state == kuf_pkg::ST_FIX && (is_root || step_cap)) begin
        total <= sum[kuf_pkg::TOT_W] ? kuf_pkg::TOT_MAX : sum[kuf_pkg::TOT_W-1:0];
        if (count != kuf_pkg::CNT_MAX) count <= count + 1'b1;
        acc <= 1'b1;
      end
      if (state == kuf_pkg::ST_RESULT && !res_valid) begin
        res_valid    <= 1'b1;
        res.accepted <= acc;
        res.bad      <= cur.bad;
        res.total    <= total;
        res.count    <= count;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x     <= x_next;
    steps <= steps_next;
    if (state == kuf_pkg::ST_IDLE && cmd_valid) cur <= cmd;
    if (state == kuf_pkg::ST_WALKA && (is_root || step_cap)) root_a <= x;
    if (state == kuf_pkg::ST_RDLINK) link <= ({1'b0, pval} >= MAXN) ? cur.node_b : pval;
  end

  `KUF_ASSERT_IMP(a_take_idle, clk, rst, cmd_take, state == kuf_pkg::ST_IDLE,
    "command taken while busy")
  `KUF_ASSERT_NEXT(a_clear_zero, clk, rst,
    state == kuf_pkg::ST_CLEAR && state_next == kuf_pkg::ST_RESULT,
    total == '0 && count == '0, "clear left totals")
  `KUF_ASSERT_IMP(a_we_states, clk, rst, we,
    state == kuf_pkg::ST_CLEAR || state == kuf_pkg::ST_FIX, "stray table write")

endmodule
`default_nettype wire

FILE: src/kruskal_union_find_mst.sv
// Kruskal spanning-forest engine over a union-find parent table.
// Input channel: push/full with opcode, edge_from, edge_to, edge_weight.
//   opcode clear re-roots every node below node_count and zeroes totals;
//   opcode edge walks both endpoints to their roots and links them if apart.
// Result channel: empty/pop, one result per transaction carrying
//   edge_accepted, bad_edge, tree_weight and edges_taken.
// Configuration: cfg_we/cfg_data write node_count; write only while idle.
// Edge processing: the walks follow the parent links from each endpoint in
//   turn, and an edge that links also rewrites the from-side path; the single
//   read port of the parent table serializes these steps.
// The engine can take the next command in the cycle after it posts a result.
// A two-entry command queue takes new transactions while one executes.
// Reset: totals zero, node_count 1024; a clearing pass over
//   min(MAX_NODES, 1024) table entries makes every node its own root while
//   incoming transactions wait in the queue.
// If pop is held low the finished result waits, the engine stalls and the
//   queue fills until full rises.
`default_nettype none
module kruskal_union_find_mst #(
  parameter int unsigned MAX_NODES = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       opcode,
  input  wire logic [kuf_pkg::NODE_W-1:0] edge_from,
  input  wire logic [kuf_pkg::NODE_W-1:0] edge_to,
  input  wire logic [kuf_pkg::WGT_W-1:0]  edge_weight,
  output logic                            empty,
  input  wire logic                       pop,
  output logic                            edge_accepted,
  output logic                            bad_edge,
  output logic [kuf_pkg::TOT_W-1:0]       tree_weight,
  output logic [kuf_pkg::CNT_W-1:0]       edges_taken,
  input  wire logic                       cfg_we,
  input  wire logic [kuf_pkg::CFG_W-1:0]  cfg_data
);

  localparam logic [kuf_pkg::CFG_W-1:0] MAXN =
    (MAX_NODES > 1024) ? 11'd1024 : kuf_pkg::CFG_W'(MAX_NODES);

  logic [kuf_pkg::CFG_W-1:0] node_count;
  logic [kuf_pkg::CFG_W-1:0] node_lim;
  logic                      cmd_valid, cmd_take, res_valid;
  kuf_pkg::cmd_t             cmd;
  kuf_pkg::res_t             res;

  // Hold the node count register
  always_ff @(posedge clk) begin
    if (rst) node_count <= 11'd1024;
    else if (cfg_we) node_count <= cfg_data;
  end

  // Cap the node count at the table size
  assign node_lim = (node_count < MAXN) ? node_count : MAXN;

  kuf_front u_front (
    .clk, .rst, .push, .full, .opcode, .edge_from, .edge_to, .edge_weight,
    .limit(node_lim), .cmd_valid, .cmd, .cmd_take
  );

  kuf_engine #(.MAX_NODES(MAX_NODES)) u_engine (
    .clk, .rst, .limit(node_lim), .cmd_valid, .cmd, .cmd_take,
    .res_valid, .res, .res_take(pop && res_valid)
  );

  assign empty         = !res_valid;
  assign edge_accepted = res.accepted;
  assign bad_edge      = res.bad;
  assign tree_weight   = res.total;
  assign edges_taken   = res.count;

endmodule
`default_nettype wire

FILE: bench/kruskal_union_find_mst_checker.sv
`default_nettype none
module kruskal_union_find_mst_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic                       full,
  input  wire logic                       opcode,
  input  wire logic [kuf_pkg::NODE_W-1:0] edge_from,
  input  wire logic [kuf_pkg::NODE_W-1:0] edge_to,
  input  wire logic [kuf_pkg::WGT_W-1:0]  edge_weight,
  input  wire logic                       empty,
  input  wire logic                       pop,
  input  wire logic                       edge_accepted,
  input  wire logic                       bad_edge,
  input  wire logic [kuf_pkg::TOT_W-1:0]  tree_weight,
  input  wire logic [kuf_pkg::CNT_W-1:0]  edges_taken,
  input  wire logic                       cfg_we,
  input  wire logic [kuf_pkg::CFG_W-1:0]  cfg_data,
  output int                              errors,
  output int                              pending
);

  localparam int unsigned NODES = 1024;

  // Shadow forest and totals
  logic [kuf_pkg::NODE_W-1:0] forest [NODES];
  logic [kuf_pkg::TOT_W-1:0]  span_total;
  logic [kuf_pkg::CNT_W-1:0]  span_edges;
  logic [kuf_pkg::CFG_W-1:0]  vertex_count;
  kuf_pkg::res_t              span_results [$];

  function automatic logic [kuf_pkg::NODE_W-1:0] find_root(logic [kuf_pkg::NODE_W-1:0] x);
    int steps;
    steps = 0;
    while (forest[x] != x && steps < NODES) begin
      x = forest[x];
      steps++;
    end
    return x;
  endfunction

  // Apply one transaction to the shadow forest and return its result
  function automatic kuf_pkg::res_t apply_op(logic op, logic [kuf_pkg::NODE_W-1:0] a,
                                             logic [kuf_pkg::NODE_W-1:0] b,
                                             logic [kuf_pkg::WGT_W-1:0] w);
    kuf_pkg::res_t r;
    int lim;
    int steps;
    logic [kuf_pkg::NODE_W-1:0] x, nx, link;
    r = '0;
    lim = (vertex_count < NODES) ? int'(vertex_count) : NODES;
    if (op == kuf_pkg::OP_CLEAR) begin
      for (int i = 0; i < lim; i++) forest[i] = kuf_pkg::NODE_W'(i);
      span_total = '0;
      span_edges = '0;
    end else if (a >= lim || b >= lim) begin
      r.bad = 1'b1;
    end else if (find_root(a) != find_root(b)) begin
      // Compress the from-side path onto edge_to, hang its root under parent of edge_to
      link = forest[b];
      x = a;
      steps = 0;
      while (forest[x] != x && steps < NODES) begin
        nx = forest[x];
        forest[x] = b;
        x = nx;
        steps++;
      end
      forest[x] = link;
      if (kuf_pkg::TOT_MAX - span_total < kuf_pkg::TOT_W'(w)) span_total = kuf_pkg::TOT_MAX;
      else span_total = span_total + kuf_pkg::TOT_W'(w);
      if (span_edges != kuf_pkg::CNT_MAX) span_edges = span_edges + 1'b1;
      r.accepted = 1'b1;
    end
    r.total = span_total;
    r.count = span_edges;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    kuf_pkg::res_t want;
    if (rst) begin
      for (int i = 0; i < NODES; i++) forest[i] = kuf_pkg::NODE_W'(i);
      span_total = '0;
      span_edges = '0;
      vertex_count = kuf_pkg::CFG_W'(1024);
      span_results.delete();
      errors = 0;
    end else begin
      if (cfg_we) vertex_count = cfg_data;
      if (push && !full)
        span_results.insert(span_results.size(),
                            apply_op(opcode, edge_from, edge_to, edge_weight));
      if (pop && !empty) begin
        if (span_results.size() == 0) begin
          $display("%0t: result transaction with none expected", $time);
          errors++;
        end else begin
          want = span_results.pop_front();
          if (edge_accepted !== want.accepted)
            report("edge_accepted", 64'(edge_accepted), 64'(want.accepted));
          if (bad_edge !== want.bad)
            report("bad_edge", 64'(bad_edge), 64'(want.bad));
          if (tree_weight !== want.total)
            report("tree_weight", 64'(tree_weight), 64'(want.total));
          if (edges_taken !== want.count)
            report("edges_taken", 64'(edges_taken), 64'(want.count));
        end
      end
    end
    pending <= span_results.size();
  end
endmodule
`default_nettype wire

FILE: bench/kruskal_union_find_mst_test.sv
`default_nettype none
module kruskal_union_find_mst_test;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic opcode = kuf_pkg::OP_CLEAR;
  logic [kuf_pkg::NODE_W-1:0] edge_from = '0;
  logic [kuf_pkg::NODE_W-1:0] edge_to = '0;
  logic [kuf_pkg::WGT_W-1:0] edge_weight = '0;
  logic pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [kuf_pkg::CFG_W-1:0] cfg_data = '0;
  logic full, empty, edge_accepted, bad_edge;
  logic [kuf_pkg::TOT_W-1:0] tree_weight;
  logic [kuf_pkg::CNT_W-1:0] edges_taken;
  int errors, pending;
  int idle_cycles = 0;
  int sent = 0;
  bit no_gaps = 0;
  bit hold_rx = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  kruskal_union_find_mst uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .edge_from(edge_from), .edge_to(edge_to), .edge_weight(edge_weight),
    .empty(empty), .pop(pop), .edge_accepted(edge_accepted), .bad_edge(bad_edge),
    .tree_weight(tree_weight), .edges_taken(edges_taken),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  kruskal_union_find_mst_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .edge_from(edge_from), .edge_to(edge_to), .edge_weight(edge_weight),
    .empty(empty), .pop(pop), .edge_accepted(edge_accepted), .bad_edge(bad_edge),
    .tree_weight(tree_weight), .edges_taken(edges_taken),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  // Offer one transaction, hold until accepted, then maybe idle
  task automatic send(logic op, int a, int b, logic [kuf_pkg::WGT_W-1:0] w);
    int r, gap;
    push <= 1'b1;
    opcode <= op;
    edge_from <= kuf_pkg::NODE_W'(a);
    edge_to <= kuf_pkg::NODE_W'(b);
    edge_weight <= w;
    do @(posedge clk); while (full);
    sent++;
    r = $urandom_range(0, 99);
    gap = (no_gaps || r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain every outstanding result before touching the register
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_nodes(int n);
    cfg_we <= 1'b1;
    cfg_data <= kuf_pkg::CFG_W'(n);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls plus one long hold-off on request
  initial begin
    int rx_wait;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        hold_rx = 0;
        pop <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (rx_wait > 0) begin
        pop <= 1'b0;
        rx_wait--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 99) < 15)
          rx_wait = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("kruskal_union_find_mst_test failed");
      $finish;
    end
  end

  initial begin
    int nc, len;
    logic [kuf_pkg::WGT_W-1:0] w;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: full-size forest, extremes, self loop, same tree
    send(kuf_pkg::OP_CLEAR, 0, 0, 0);
    send(kuf_pkg::OP_EDGE, 0, 1023, 32'h0);
    send(kuf_pkg::OP_EDGE, 1023, 0, 32'h1);
    send(kuf_pkg::OP_EDGE, 5, 5, 32'h2);
    send(kuf_pkg::OP_EDGE, 1, 2, 32'hFFFFFFFF);
    send(kuf_pkg::OP_EDGE, 2, 3, 32'hFFFFFFFF);
    send(kuf_pkg::OP_EDGE, 3, 1, 32'hFFFFFFFF);
    drain();
    // Shrink without clearing: stored links stay in use
    write_nodes(4);
    send(kuf_pkg::OP_EDGE, 4, 0, 32'h5);
    send(kuf_pkg::OP_EDGE, 0, 4, 32'h5);
    send(kuf_pkg::OP_EDGE, 3, 0, 32'h6);
    send(kuf_pkg::OP_CLEAR, 0, 0, 0);
    send(kuf_pkg::OP_EDGE, 0, 1, 32'h7);
    send(kuf_pkg::OP_EDGE, 2, 3, 32'h8);
    send(kuf_pkg::OP_EDGE, 1, 3, 32'h9);
    send(kuf_pkg::OP_EDGE, 0, 3, 32'hA);
    drain();
    // Zero vertices: everything is bad, clear touches nothing
    write_nodes(0);
    send(kuf_pkg::OP_EDGE, 0, 0, 32'h1);
    send(kuf_pkg::OP_CLEAR, 0, 0, 0);
    send(kuf_pkg::OP_EDGE, 0, 1, 32'h1);
    drain();
    // Count above the table size is capped
    write_nodes(2047);
    send(kuf_pkg::OP_EDGE, 1023, 1022, 32'h3);
    send(kuf_pkg::OP_EDGE, 1022, 0, 32'h4);
    drain();
    write_nodes(1);
    send(kuf_pkg::OP_CLEAR, 0, 0, 0);
    send(kuf_pkg::OP_EDGE, 0, 0, 32'h1);
    send(kuf_pkg::OP_EDGE, 0, 1, 32'h1);
    drain();

    // Span all 1024 vertices to reach the edge count ceiling
    write_nodes(1024);
    no_gaps = 1;
    send(kuf_pkg::OP_CLEAR, 0, 0, 0);
    for (int i = 0; i < 1023; i++)
      send(kuf_pkg::OP_EDGE, i + 1, i, 32'hFFFFFFF0 + (i % 16));
    send(kuf_pkg::OP_EDGE, 0, 1023, 32'hFFFFFFFF);
    no_gaps = 0;
    drain();

    // Random graphs; first one runs against a stalled receiver
    hold_rx = 1;
    while (sent < 1700) begin
      nc = ($urandom_range(0, 11) == 0) ? 1024 : $urandom_range(2, 100);
      write_nodes(nc);
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) != 0) send(kuf_pkg::OP_CLEAR, 0, 0, 0);
      len = $urandom_range(5, 60);
      w = $urandom;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 4) begin
          send(kuf_pkg::OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
        end else if ($urandom_range(0, 99) < 10) begin
          send(kuf_pkg::OP_EDGE, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
        end else begin
          w = ($urandom_range(0, 99) < 3) ? $urandom : w + $urandom_range(0, 3);
          send(kuf_pkg::OP_EDGE, $urandom_range(0, nc - 1), $urandom_range(0, nc - 1), w);
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("kruskal_union_find_mst_test passed");
    end else begin
      $display("kruskal_union_find_mst_test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
